FILE: hw/rtl/file_successor_predictor_core_defines.svh
// Assertion macros for the file successor predictor
`ifndef FILE_SUCCESSOR_PREDICTOR_CORE_DEFINES_SVH
`define FILE_SUCCESSOR_PREDICTOR_CORE_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define FSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off during reset
`define FSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/fsp_pkg.sv
// Package: word types, widths and controller states of the file successor predictor
package fsp_pkg;
	localparam int FKEY_W = 32;
	localparam int TICK_W = 32;
	localparam int CNT_W = 16;

	typedef struct packed {
		logic              func;
		logic [FKEY_W-1:0] file_key;
		logic [TICK_W-1:0] tick;
	} in_word_t;

	typedef struct packed {
		logic [FKEY_W-1:0] prefetch_key;
		logic              last_of_run;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_NOTE_RD,
		ST_NOTE_CHK,
		ST_NOTE_WR,
		ST_PRED_RD,
		ST_PRED_ENT,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_FLUSH
	} fsp_state_t;
endpackage

FILE: hw/rtl/fsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
module fsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hw/rtl/fsp_oreg.sv
// Output register: holds one result word for the receiver
module fsp_oreg import fsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  out_word_t push_word,
	output logic      push_ready,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);
	logic      full_q;
	out_word_t word_q;

	assign push_ready = !full_q || !out_stall;
	assign out_valid = full_q;
	assign out_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			full_q <= 1'b1;
		end else if (!out_stall) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			word_q <= push_word;
		end
	end
endmodule

FILE: hw/rtl/fsp_ctrl.sv
// Controller: table scan, successor update and prediction over the entry and slot RAMs
`include "file_successor_predictor_core_defines.svh"
module fsp_ctrl import fsp_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int SUCCESSOR_SLOTS = 4,
	parameter int KEY_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      enable,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      push_valid,
	output out_word_t push_word,
	input  logic      push_ready
);
	localparam int EW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int NW = $clog2(SUCCESSOR_SLOTS + 1);
	localparam int SDEPTH = TABLE_ENTRIES * SUCCESSOR_SLOTS;
	localparam int SAW = $clog2(SDEPTH);
	localparam int ENT_W = KEY_BITS + TICK_W + CNT_W + NW;
	localparam int SLOT_W = KEY_BITS + CNT_W;

	fsp_state_t state_q, state_d;

	logic [KEY_BITS-1:0] prev_key_q, cur_key_q, pend_key_q;
	logic                prev_valid_q, pend_v_q;
	logic [TICK_W-1:0]   tick_q, oldest_q;
	logic [CW-1:0]       fill_q, addr_q;
	logic                chk_s1;
	logic [EW-1:0]       idx_s1, ent_q, victim_q, kidx_q, pred_idx_q;
	logic                pfound_q, kfound_q, pred_found_q;
	logic [CNT_W-1:0]    etotal_q, low_q, cnt_q;
	logic [NW-1:0]       enslot_q, j_q, sel_q, lows_q;

	logic              ent_re, ent_we;
	logic [EW-1:0]     ent_raddr;
	logic [ENT_W-1:0]  ent_wdata, ent_rdata;
	logic              slot_re, slot_we;
	logic [SAW-1:0]    slot_raddr, slot_waddr;
	logic [SLOT_W-1:0] slot_wdata, slot_rdata;

	logic [63:0]         key_ext;
	logic [KEY_BITS-1:0] key_in;
	logic [63:0]         pend_ext;
	logic [KEY_BITS-1:0] rd_key;
	logic [TICK_W-1:0]   rd_tick;
	logic [CNT_W-1:0]    rd_total;
	logic [NW-1:0]       rd_nslot;
	logic [KEY_BITS-1:0] rs_key;
	logic [CNT_W-1:0]    rs_cnt;
	logic                scan_done, evict, same_key, slot_hit, qualify, pred_st;
	logic [EW-1:0]       note_e, rbase;

	assign key_ext = 64'(in_word.file_key);
	assign key_in = key_ext[KEY_BITS-1:0];
	assign pend_ext = 64'(pend_key_q);

	assign rd_key = ent_rdata[ENT_W-1 -: KEY_BITS];
	assign rd_tick = ent_rdata[NW+CNT_W +: TICK_W];
	assign rd_total = ent_rdata[NW +: CNT_W];
	assign rd_nslot = ent_rdata[NW-1:0];
	assign rs_key = slot_rdata[SLOT_W-1 -: KEY_BITS];
	assign rs_cnt = slot_rdata[CNT_W-1:0];

	assign scan_done = (addr_q >= fill_q) && !chk_s1;
	assign evict = !pfound_q && (fill_q == CW'(TABLE_ENTRIES));
	assign same_key = prev_valid_q && (prev_key_q == cur_key_q);
	assign note_e = pfound_q ? ent_q : (evict ? victim_q : fill_q[EW-1:0]);
	assign slot_hit = (rs_key == cur_key_q);
	assign qualify = {1'b0, rs_cnt, 1'b0} >= {2'b00, etotal_q};
	assign pred_st = (state_q == ST_SLOT_RD) || (state_q == ST_SLOT_CHK);
	assign rbase = pred_st ? pred_idx_q : ent_q;

	fsp_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_q),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	fsp_ram #(.WIDTH(SLOT_W), .DEPTH(SDEPTH)) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_word.func && enable && key_in != '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = prev_valid_q ? ST_NOTE_RD : ST_PRED_RD;
				end
			end
			ST_NOTE_RD: state_d = (j_q == enslot_q) ? ST_NOTE_WR : ST_NOTE_CHK;
			ST_NOTE_CHK: state_d = slot_hit ? ST_NOTE_WR : ST_NOTE_RD;
			ST_NOTE_WR: state_d = ST_PRED_RD;
			ST_PRED_RD: state_d = pred_found_q ? ST_PRED_ENT : ST_FLUSH;
			ST_PRED_ENT: state_d = ST_SLOT_RD;
			ST_SLOT_RD: state_d = (j_q == enslot_q) ? ST_FLUSH : ST_SLOT_CHK;
			ST_SLOT_CHK: begin
				if (!qualify || !pend_v_q || push_ready) begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || push_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		ent_re = 1'b0;
		ent_raddr = addr_q[EW-1:0];
		ent_we = 1'b0;
		ent_wdata = {prev_key_q, tick_q, CNT_W'(etotal_q + 1'b1), enslot_q};
		slot_re = 1'b0;
		slot_raddr = SAW'(SAW'(rbase) * SAW'(SUCCESSOR_SLOTS) + SAW'(j_q));
		slot_we = 1'b0;
		slot_waddr = SAW'(SAW'(ent_q) * SAW'(SUCCESSOR_SLOTS) + SAW'(sel_q));
		slot_wdata = {cur_key_q, cnt_q};
		push_valid = 1'b0;
		push_word = '{prefetch_key: pend_ext[FKEY_W-1:0], last_of_run: 1'b0};
		case (state_q)
			ST_SCAN: ent_re = (addr_q < fill_q);
			ST_NOTE_RD, ST_SLOT_RD: slot_re = (j_q != enslot_q);
			ST_NOTE_WR: begin
				ent_we = 1'b1;
				slot_we = 1'b1;
			end
			ST_PRED_RD: begin
				ent_re = pred_found_q;
				ent_raddr = pred_idx_q;
			end
			ST_SLOT_CHK: push_valid = qualify && pend_v_q;
			ST_FLUSH: begin
				push_valid = pend_v_q;
				push_word.last_of_run = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			prev_valid_q <= 1'b0;
			prev_key_q <= '0;
			pend_v_q <= 1'b0;
			chk_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					chk_s1 <= 1'b0;
					pend_v_q <= 1'b0;
					if (in_valid && in_word.func) begin
						fill_q <= '0;
						prev_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					chk_s1 <= (addr_q < fill_q);
					if (scan_done && prev_valid_q && !pfound_q && !evict) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_SLOT_CHK: begin
					if ((!pend_v_q || push_ready) && qualify) begin
						pend_v_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || push_ready) begin
						pend_v_q <= 1'b0;
						prev_key_q <= cur_key_q;
						prev_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_key_q <= key_in;
				tick_q <= in_word.tick;
				addr_q <= '0;
				pfound_q <= 1'b0;
				kfound_q <= 1'b0;
				oldest_q <= '1;
				victim_q <= '0;
			end
			ST_SCAN: begin
				if (addr_q < fill_q) begin
					addr_q <= addr_q + 1'b1;
				end
				idx_s1 <= addr_q[EW-1:0];
				if (chk_s1) begin
					if (prev_valid_q && !pfound_q && rd_key == prev_key_q) begin
						pfound_q <= 1'b1;
						ent_q <= idx_s1;
						etotal_q <= rd_total;
						enslot_q <= rd_nslot;
					end else if (!pfound_q && rd_tick < oldest_q) begin
						oldest_q <= rd_tick;
						victim_q <= idx_s1;
					end
					if (!kfound_q && rd_key == cur_key_q) begin
						kfound_q <= 1'b1;
						kidx_q <= idx_s1;
					end
				end
				if (scan_done) begin
					ent_q <= note_e;
					if (!pfound_q) begin
						etotal_q <= '0;
						enslot_q <= '0;
					end
					j_q <= '0;
					low_q <= '1;
					lows_q <= '0;
					pred_found_q <= same_key ||
						(kfound_q && !(prev_valid_q && evict && kidx_q == victim_q));
					pred_idx_q <= same_key ? note_e : kidx_q;
				end
			end
			ST_NOTE_RD: begin
				if (j_q == enslot_q) begin
					cnt_q <= CNT_W'(1);
					if (enslot_q < NW'(SUCCESSOR_SLOTS)) begin
						sel_q <= enslot_q;
						enslot_q <= enslot_q + 1'b1;
					end else begin
						sel_q <= lows_q;
					end
				end
			end
			ST_NOTE_CHK: begin
				if (slot_hit) begin
					sel_q <= j_q;
					cnt_q <= rs_cnt + 1'b1;
				end else begin
					if (rs_cnt < low_q) begin
						low_q <= rs_cnt;
						lows_q <= j_q;
					end
					j_q <= j_q + 1'b1;
				end
			end
			ST_PRED_ENT: begin
				etotal_q <= rd_total;
				enslot_q <= rd_nslot;
				j_q <= '0;
			end
			ST_SLOT_CHK: begin
				if (!qualify || !pend_v_q || push_ready) begin
					j_q <= j_q + 1'b1;
					if (qualify) begin
						pend_key_q <= rs_key;
					end
				end
			end
			default: ;
		endcase
	end

	`FSP_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(TABLE_ENTRIES), "fill count beyond table")
	`FSP_ASSERT_IMP(a_push_pend, push_valid, pend_v_q, "word pushed with nothing pending")
	`FSP_ASSERT_NXT(a_clear, in_valid && !in_stall && in_word.func, fill_q == '0 && !prev_valid_q, "clear left table filled")
	`FSP_ASSERT_IMP(a_slot_count, state_q == ST_NOTE_WR, enslot_q != '0 && enslot_q <= NW'(SUCCESSOR_SLOTS), "slot count out of range at write")
endmodule

FILE: hw/rtl/file_successor_predictor_core.sv
// Top level of the file successor predictor: enable register, controller, output register
// Usage:
//   Input channel in_valid/in_stall/in_word carries {func, file_key, tick}.
//   func=1 clears the table and the previous key; func=0 with a nonzero key
//   records a transition from the previous key and predicts successors.
//   Output channel out_valid/out_stall/out_word carries {prefetch_key,
//   last_of_run}; zero to SUCCESSOR_SLOTS words per item, last one flagged.
//   cfg_we/cfg_wdata writes predict_enable (reset 1); when 0, observe words
//   are dropped. Clears and ignored words are taken in the idle state.
// Flow:
//   One item at a time. An observe word goes through a pipelined entry scan
//   (one entry RAM read per cycle), a successor slot update and a
//   prediction pass over the slots. The output register holds one word; a
//   stalled receiver holds the controller, and in_stall stays high until the
//   last word of an item is in the output register.
// Reset: table empty (fill count zero), no previous key, no RAM sweep.
module file_successor_predictor_core import fsp_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int SUCCESSOR_SLOTS = 4,
	parameter int KEY_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	logic      enable_q;
	logic      push_valid, push_ready;
	out_word_t push_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	fsp_ctrl #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.SUCCESSOR_SLOTS(SUCCESSOR_SLOTS),
		.KEY_BITS       (KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.push_valid(push_valid),
		.push_word (push_word),
		.push_ready(push_ready)
	);

	fsp_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_word (push_word),
		.push_ready(push_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);
endmodule

FILE: tb/testbench.sv
// Testbench for file_successor_predictor_core: directed table, enable toggling, then random words, model-checked
`timescale 1ns / 100ps
module testbench;
	import fsp_pkg::*;

	localparam int ENTRIES = 64;
	localparam int SLOTS = 4;
	localparam int QUIET = 120;
	localparam int WATCH_LIMIT = 6000;
	localparam int HOLD_LEN = 400;
	localparam bit FN_OPEN = 1'b0;
	localparam bit FN_CLEAR = 1'b1;

	typedef struct {
		bit        func;
		bit [31:0] key;
		bit [31:0] tick;
		bit        typed;
		bit [31:0] want;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;
	logic      cfg_we;
	logic      cfg_wdata;

	bit [31:0] trig_key [ENTRIES];
	bit        trig_ok [ENTRIES];
	bit [31:0] use_tick [ENTRIES];
	bit [15:0] trig_total [ENTRIES];
	bit [31:0] succ_key [ENTRIES][SLOTS];
	bit        succ_ok [ENTRIES][SLOTS];
	bit [15:0] succ_cnt [ENTRIES][SLOTS];
	bit [31:0] prev_key;
	bit        prev_ok;
	bit        enable;

	out_word_t prefetch_q[$];
	out_word_t step_q[$];
	int        errors;
	bit        hold_long;
	int        idle_cycles;

	file_successor_predictor_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			trig_ok[i] = 0;
			trig_total[i] = 0;
			use_tick[i] = 0;
		end
		prev_key = 0;
		prev_ok = 0;
	endfunction

	function automatic void claim(int e, bit [31:0] key, bit [31:0] tick);
		trig_key[e] = key;
		trig_ok[e] = 1;
		trig_total[e] = 0;
		use_tick[e] = tick;
		for (int j = 0; j < SLOTS; j++) begin
			succ_ok[e][j] = 0;
			succ_cnt[e][j] = 0;
		end
	endfunction

	// expected prefetch words for one accepted word, collected in step_q after clearing it
	function automatic void model_open(in_word_t w);
		int e;
		int victim;
		int slot;
		int free_slot;
		bit [31:0] oldest;
		bit [15:0] low_cnt;
		bit hit;
		step_q.delete();
		if (w.func == FN_CLEAR) begin
			wipe_table();
			return;
		end
		if (!enable || w.file_key == 0)
			return;
		if (prev_ok) begin
			e = -1;
			victim = 0;
			oldest = '1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!trig_ok[i]) begin
					claim(i, prev_key, w.tick);
					e = i;
					break;
				end
				if (trig_key[i] == prev_key) begin
					use_tick[i] = w.tick;
					e = i;
					break;
				end
				if (use_tick[i] < oldest) begin
					oldest = use_tick[i];
					victim = i;
				end
			end
			if (e < 0) begin
				claim(victim, prev_key, w.tick);
				e = victim;
			end
			hit = 0;
			free_slot = -1;
			slot = 0;
			low_cnt = '1;
			for (int j = 0; j < SLOTS; j++) begin
				if (!succ_ok[e][j]) begin
					if (free_slot < 0)
						free_slot = j;
					continue;
				end
				if (succ_key[e][j] == w.file_key) begin
					succ_cnt[e][j]++;
					trig_total[e]++;
					hit = 1;
					break;
				end
				if (succ_cnt[e][j] < low_cnt) begin
					low_cnt = succ_cnt[e][j];
					slot = j;
				end
			end
			if (!hit) begin
				if (free_slot >= 0)
					slot = free_slot;
				succ_key[e][slot] = w.file_key;
				succ_ok[e][slot] = 1;
				succ_cnt[e][slot] = 1;
				trig_total[e]++;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (!trig_ok[i] || trig_key[i] != w.file_key)
				continue;
			for (int j = 0; j < SLOTS; j++) begin
				if (!succ_ok[i][j])
					break;
				if ({succ_cnt[i][j], 1'b0} < {1'b0, trig_total[i]})
					continue;
				step_q.push_back('{prefetch_key: succ_key[i][j], last_of_run: 1'b0});
			end
			break;
		end
		if (step_q.size() > 0)
			step_q[step_q.size()-1].last_of_run = 1'b1;
		prev_key = w.file_key;
		prev_ok = 1;
	endfunction

	task automatic send(bit func, bit [31:0] key, bit [31:0] tick);
		int gap;
		in_word_t w;
		w.func = func;
		w.file_key = key;
		w.tick = tick;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		model_open(w);
		foreach (step_q[k])
			prefetch_q.push_back(step_q[k]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (prefetch_q.size() == 0);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		enable = v;
	endtask

	// receiving side: random stall before each word, bursts without stall
	initial begin
		int n;
		bit burst;
		out_word_t want;
		out_stall = 1'b1;
		burst = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				burst = ~burst;
			n = burst ? 0 : $urandom_range(0, 8);
			if (hold_long) begin
				n = HOLD_LEN;
				hold_long = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (prefetch_q.size() == 0) begin
				$error("unexpected word: prefetch_key %h last_of_run %b",
					out_word.prefetch_key, out_word.last_of_run);
				errors++;
			end else begin
				want = prefetch_q.pop_front();
				if (out_word.prefetch_key !== want.prefetch_key) begin
					$error("prefetch_key: expected %h actual %h",
						want.prefetch_key, out_word.prefetch_key);
					errors++;
				end
				if (out_word.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b actual %b",
						want.last_of_run, out_word.last_of_run);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	row_t rows[] = '{
		'{FN_OPEN, 32'h1, 32'h1, 0, 0},
		'{FN_OPEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0},
		'{FN_OPEN, 32'h1, 32'h2, 1, 32'hFFFF_FFFF},
		'{FN_OPEN, 32'h0, 32'h3, 0, 0},
		'{FN_OPEN, 32'h2, 32'h3, 0, 0},
		'{FN_OPEN, 32'h1, 32'h4, 0, 0},
		'{FN_OPEN, 32'h3, 32'h0, 0, 0},
		'{FN_OPEN, 32'h1, 32'h5, 0, 0},
		'{FN_OPEN, 32'h4, 32'h6, 0, 0},
		'{FN_OPEN, 32'h1, 32'h7, 0, 0},
		'{FN_OPEN, 32'h5, 32'h8, 0, 0},
		'{FN_OPEN, 32'h1, 32'h9, 0, 0},
		'{FN_OPEN, 32'h6, 32'hA, 0, 0},
		'{FN_OPEN, 32'h1, 32'hB, 0, 0},
		'{FN_OPEN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0},
		'{FN_OPEN, 32'h1, 32'hC, 0, 0},
		'{FN_CLEAR, 32'h1234_5678, 32'hFFFF_FFFF, 0, 0},
		'{FN_OPEN, 32'h1, 32'hD, 0, 0},
		'{FN_OPEN, 32'h6, 32'hE, 0, 0},
		'{FN_CLEAR, 32'h0, 32'h0, 0, 0},
		'{FN_OPEN, 32'h6, 32'hF, 0, 0}
	};

	initial begin
		bit [31:0] key;
		bit [31:0] tick;
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		errors = 0;
		hold_long = 0;
		idle_cycles = 0;
		enable = 1;
		for (int i = 0; i < ENTRIES; i++)
			for (int j = 0; j < SLOTS; j++) begin
				succ_ok[i][j] = 0;
				succ_cnt[i][j] = 0;
			end
		wipe_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send(rows[i].func, rows[i].key, rows[i].tick);
			if (rows[i].typed && (step_q.size() != 1
				|| step_q[0].prefetch_key != rows[i].want)) begin
				$error("prefetch_key: expected %h actual %h from table row %0d",
					rows[i].want,
					(step_q.size() > 0) ? step_q[0].prefetch_key : 32'h0, i);
				errors++;
			end
		end

		write_enable(1'b0);
		send(FN_OPEN, 32'h6, 32'h20);
		send(FN_OPEN, 32'hFFFF_FFFF, 32'h21);
		send(FN_CLEAR, 32'h0, 32'h22);
		send(FN_OPEN, 32'h1, 32'h23);
		write_enable(1'b1);
		write_enable(1'b0);
		write_enable(1'b1);

		tick = 32'h100;
		for (int n = 0; n < 400; n++) begin
			if (n == 150)
				hold_long = 1;
			if (n == 250) begin
				in_valid <= 1'b0;
				wait (prefetch_q.size() == 0);
			end
			r = $urandom_range(0, 99);
			tick = tick + $urandom_range(0, 3);
			if (r < 2) begin
				send(FN_CLEAR, $urandom, $urandom);
				continue;
			end
			if (r < 5)
				key = 0;
			else if (r < 10)
				key = $urandom;
			else if (r < 40)
				key = $urandom_range(1, 90);
			else
				key = $urandom_range(1, 8);
			send(FN_OPEN, key, (r % 17 == 0) ? $urandom : tick);
		end
		in_valid <= 1'b0;

		wait (prefetch_q.size() == 0);
		repeat (QUIET) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
